FILE: hw/rtl/delta_list_record_decoder_assert.svh
// Assertion macros for the delta list record decoder.
// Used by the top level only; no other dependencies.
`ifndef DELTA_LIST_RECORD_DECODER_ASSERT_SVH
`define DELTA_LIST_RECORD_DECODER_ASSERT_SVH

`ifndef SYNTHESIS

`define DLRD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define DLRD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define DLRD_ASSERT(label, clk, rst_n, prop, msg)

`define DLRD_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

FILE: hw/rtl/dlrd_pkg.sv
// Types and constants shared by the delta list record decoder modules.
// No dependencies.
package dlrd_pkg;

    localparam logic [2:0] PH_GRP_LEN  = 3'd0;
    localparam logic [2:0] PH_PREFIX   = 3'd1;
    localparam logic [2:0] PH_COUNT    = 3'd2;
    localparam logic [2:0] PH_ENT_LEN  = 3'd3;
    localparam logic [2:0] PH_ENT_DATA = 3'd4;

    localparam logic [7:0] COUNT_BYTES = 8'd3;

    localparam logic KIND_ENTRY  = 1'b0;
    localparam logic KIND_PREFIX = 1'b1;

    typedef struct packed {
        logic       start_of_list;
        logic [7:0] data_byte;
    } t_in_beat;

    typedef struct packed {
        logic        record_kind;
        logic [63:0] value;
        logic [31:0] out_offset;
    } t_result;

    typedef struct packed {
        logic [2:0] phase;
        logic [7:0] bytes_left;
    } t_dec_status;

endpackage

FILE: hw/rtl/dlrd_in_stage.sv
// Input register of the delta list record decoder.
// Depends on dlrd_pkg.
module dlrd_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  dlrd_pkg::t_in_beat i_beat,
    input  logic              i_advance,
    output logic              o_valid,
    output dlrd_pkg::t_in_beat o_beat
);
    import dlrd_pkg::*;

    logic     r_valid;
    t_in_beat r_beat;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_beat <= i_beat;
        end
    end

endmodule

FILE: hw/rtl/dlrd_decode.sv
// Decode state and next-state logic: one byte per enabled cycle.
// Depends on dlrd_pkg.
module dlrd_decode #(
    parameter int ENTRY_BYTES  = 8,
    parameter int PREFIX_BYTES = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  dlrd_pkg::t_in_beat    i_beat,
    output logic                  o_has_result,
    output dlrd_pkg::t_result     o_result,
    output dlrd_pkg::t_dec_status o_status
);
    import dlrd_pkg::*;

    localparam logic [63:0] ENTRY_MASK  = (ENTRY_BYTES >= 8) ? {64{1'b1}} :
        ((64'd1 << (8 * ENTRY_BYTES)) - 64'd1);
    localparam logic [63:0] PREFIX_MASK = (PREFIX_BYTES >= 8) ? {64{1'b1}} :
        ((64'd1 << (8 * PREFIX_BYTES)) - 64'd1);
    localparam logic [31:0] ENTRY_INC   = 32'(ENTRY_BYTES);

    logic [2:0]  r_phase, n_phase, c_phase;
    logic [7:0]  r_bl, n_bl, c_bl;
    logic [63:0] r_ds, n_ds, c_ds;
    logic [63:0] r_ps, n_ps, c_ps;
    logic [63:0] r_es, n_es, c_es;
    logic [23:0] r_el, n_el, c_el;
    logic [31:0] r_bo, n_bo, c_bo;
    logic [63:0] w_shifted;
    logic [7:0]  w_b;
    logic        w_emit_ent;
    logic        w_emit_pfx;

    always_comb begin
        w_b     = i_beat.data_byte;
        c_phase = i_beat.start_of_list ? PH_GRP_LEN : r_phase;
        c_bl    = i_beat.start_of_list ? 8'd0  : r_bl;
        c_ds    = i_beat.start_of_list ? 64'd0 : r_ds;
        c_ps    = i_beat.start_of_list ? 64'd0 : r_ps;
        c_es    = i_beat.start_of_list ? 64'd0 : r_es;
        c_el    = i_beat.start_of_list ? 24'd0 : r_el;
        c_bo    = i_beat.start_of_list ? 32'd0 : r_bo;

        w_shifted  = {c_ds[55:0], w_b};
        n_phase    = c_phase;
        n_bl       = c_bl;
        n_ds       = c_ds;
        n_ps       = c_ps;
        n_es       = c_es;
        n_el       = c_el;
        n_bo       = c_bo;
        w_emit_ent = 1'b0;
        w_emit_pfx = 1'b0;
        o_result   = '0;

        unique case (c_phase)
            PH_PREFIX: begin
                n_ds = w_shifted;
                n_bl = c_bl - 8'd1;
                if (n_bl == 8'd0) begin
                    n_ps    = c_ps + w_shifted;
                    n_ds    = 64'd0;
                    n_el    = 24'd0;
                    n_bl    = COUNT_BYTES;
                    n_phase = PH_COUNT;
                end
            end
            PH_COUNT: begin
                n_el = {c_el[15:0], w_b};
                n_bl = c_bl - 8'd1;
                if (n_bl == 8'd0) begin
                    n_es       = 64'd0;
                    w_emit_pfx = 1'b1;
                    n_phase    = (n_el == 24'd0) ? PH_GRP_LEN : PH_ENT_LEN;
                end
            end
            PH_ENT_LEN: begin
                n_ds = 64'd0;
                if (w_b == 8'd0) begin
                    w_emit_ent = 1'b1;
                end else begin
                    n_bl    = w_b;
                    n_phase = PH_ENT_DATA;
                end
            end
            PH_ENT_DATA: begin
                n_ds = w_shifted;
                n_bl = c_bl - 8'd1;
                if (n_bl == 8'd0) begin
                    n_es       = c_es + w_shifted;
                    n_ds       = 64'd0;
                    w_emit_ent = 1'b1;
                end
            end
            default: begin
                n_ds = 64'd0;
                if (w_b == 8'd0) begin
                    n_el    = 24'd0;
                    n_bl    = COUNT_BYTES;
                    n_phase = PH_COUNT;
                end else begin
                    n_bl    = w_b;
                    n_phase = PH_PREFIX;
                end
            end
        endcase

        if (w_emit_pfx) begin
            o_result.record_kind = KIND_PREFIX;
            o_result.value       = c_ps & PREFIX_MASK;
            o_result.out_offset  = c_bo;
        end
        if (w_emit_ent) begin
            o_result.record_kind = KIND_ENTRY;
            o_result.value       = n_es & ENTRY_MASK;
            o_result.out_offset  = c_bo;
            n_bo                 = c_bo + ENTRY_INC;
            n_el                 = c_el - 24'd1;
            n_phase              = (n_el == 24'd0) ? PH_GRP_LEN : PH_ENT_LEN;
        end
        o_has_result = w_emit_pfx || w_emit_ent;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_GRP_LEN;
            r_bl    <= 8'd0;
            r_ds    <= 64'd0;
            r_ps    <= 64'd0;
            r_es    <= 64'd0;
            r_el    <= 24'd0;
            r_bo    <= 32'd0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_bl    <= n_bl;
            r_ds    <= n_ds;
            r_ps    <= n_ps;
            r_es    <= n_es;
            r_el    <= n_el;
            r_bo    <= n_bo;
        end
    end

    assign o_status.phase      = r_phase;
    assign o_status.bytes_left = r_bl;

endmodule

FILE: hw/rtl/dlrd_out_stage.sv
// Result register of the delta list record decoder.
// Depends on dlrd_pkg.
module dlrd_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic              i_has_result,
    input  dlrd_pkg::t_result i_result,
    input  logic              i_ready,
    output logic              o_valid,
    output logic              o_advance,
    output dlrd_pkg::t_result o_result
);
    import dlrd_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_advance = !r_valid || i_ready;
    assign o_valid   = r_valid;
    assign o_result  = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_load && i_has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_load && i_has_result) begin
            r_result <= i_result;
        end
    end

endmodule

FILE: hw/rtl/delta_list_record_decoder.sv
// Top level of the delta list record decoder: input register, decode, result register.
// Depends on dlrd_pkg, dlrd_in_stage, dlrd_decode, dlrd_out_stage and the assert header.
//
//  channel | dir | tdata                               | tuser
//  s_      | in  | [7:0] data_byte                     | start_of_list
//  m_      | out | [63:0] value, [95:64] out_offset    | record_kind
//
// One byte per clock while the result register is free or m_tready is high; each byte is
// captured in the input register and decoded into the result register when that register
// can advance, so a byte's result passes both registers before it can be taken.
// Reset is synchronous and clears both stage valids and all decode state.
// While a result waits on m_tready, decoding stops and the byte in the input
// register is held; s_tready is low while that register is full and cannot advance.
`include "delta_list_record_decoder_assert.svh"

module delta_list_record_decoder #(
    parameter int ENTRY_BYTES  = 8,
    parameter int PREFIX_BYTES = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] start_of_list
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // [63:0] value, [95:64] out_offset
    output logic        m_tuser    // [0] record_kind
);
    import dlrd_pkg::*;

    t_in_beat    w_in_beat;
    t_in_beat    w_reg_beat;
    logic        w_reg_valid;
    logic        w_advance;
    logic        w_has_result;
    t_result     w_result;
    t_result     w_out_result;
    t_dec_status w_status;

    assign w_in_beat.data_byte     = s_tdata;
    assign w_in_beat.start_of_list = s_tuser;

    dlrd_in_stage u_in (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_tvalid),
        .o_ready  (s_tready),
        .i_beat   (w_in_beat),
        .i_advance(w_advance),
        .o_valid  (w_reg_valid),
        .o_beat   (w_reg_beat)
    );

    dlrd_decode #(
        .ENTRY_BYTES (ENTRY_BYTES),
        .PREFIX_BYTES(PREFIX_BYTES)
    ) u_dec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_reg_valid && w_advance),
        .i_beat      (w_reg_beat),
        .o_has_result(w_has_result),
        .o_result    (w_result),
        .o_status    (w_status)
    );

    dlrd_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_reg_valid),
        .i_has_result(w_has_result),
        .i_result    (w_result),
        .i_ready     (m_tready),
        .o_valid     (m_tvalid),
        .o_advance   (w_advance),
        .o_result    (w_out_result)
    );

    assign m_tdata = {w_out_result.out_offset, w_out_result.value};
    assign m_tuser = w_out_result.record_kind;

    `DLRD_ASSERT(a_ready_when_out_free, i_clk, i_rst_n,
        !m_tvalid |-> s_tready, "s_tready low with empty result register")

    `DLRD_ASSERT(a_result_from_beat, i_clk, i_rst_n,
        (m_tvalid && !$past(m_tvalid)) |-> $past(w_reg_valid), "result without a decoded beat")

    `DLRD_ASSERT(a_data_count_live, i_clk, i_rst_n,
        (w_status.phase == PH_ENT_DATA) |-> (w_status.bytes_left != 8'd0),
        "entry data phase with no bytes left")

    `DLRD_ASSERT_ALWAYS(a_reset_clears, i_clk,
        !$past(i_rst_n) |-> (!m_tvalid && !w_reg_valid), "stage valid set after reset")

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for delta_list_record_decoder. It drives a coded byte stream with
// random gaps and stalls and checks each record against a decoder model kept in the bench.
// Depends on dlrd_pkg and the decoder RTL.
module testbench;
    import dlrd_pkg::*;

    localparam int ENTRY_BYTES  = 8;
    localparam int PREFIX_BYTES = 3;
    localparam logic [63:0] ENTRY_MASK =
        (ENTRY_BYTES >= 8) ? '1 : (64'd1 << (8 * ENTRY_BYTES)) - 64'd1;
    localparam logic [63:0] PREFIX_MASK =
        (PREFIX_BYTES >= 8) ? '1 : (64'd1 << (8 * PREFIX_BYTES)) - 64'd1;
    localparam int TARGET_BYTES = 1250;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;   // [7:0] data_byte
    logic        s_tuser = 1'b0; // [0] start_of_list
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;        // [63:0] value, [95:64] out_offset
    logic        m_tuser;        // [0] record_kind

    delta_list_record_decoder #(
        .ENTRY_BYTES (ENTRY_BYTES),
        .PREFIX_BYTES(PREFIX_BYTES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // decoder model state
    logic [2:0]  dec_phase = PH_GRP_LEN;
    logic [7:0]  dec_bytes_left = '0;
    logic [63:0] dec_shift = '0;
    logic [63:0] dec_prefix_sum = '0;
    logic [63:0] dec_entry_sum = '0;
    logic [23:0] dec_entries_left = '0;
    logic [31:0] dec_offset = '0;

    t_in_beat stream_bytes[$];
    t_result  expected_records[$];
    t_in_beat next_beat;

    int  errors = 0;
    int  cycles = 0;
    int  beats_offered = 0;
    int  beats_taken = 0;
    int  records_taken = 0;
    int  entry_count = 0;
    int  prefix_count = 0;
    int  restart_count = 0;
    int  send_gap = 0;
    int  recv_gap = 0;
    bit  send_calm = 1'b1;
    bit  recv_calm = 1'b1;
    bit  restart_due = 1'b0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp);
        errors++;
        $display("MISMATCH record %0d %s: got %h expected %h", records_taken, what, got, exp);
    endtask

    task automatic close_entry();
        t_result rec;
        rec.record_kind = KIND_ENTRY;
        rec.value       = dec_entry_sum & ENTRY_MASK;
        rec.out_offset  = dec_offset;
        expected_records.push_back(rec);
        dec_offset       = dec_offset + ENTRY_BYTES;
        dec_entries_left = dec_entries_left - 24'd1;
        dec_phase        = (dec_entries_left == '0) ? PH_GRP_LEN : PH_ENT_LEN;
    endtask

    task automatic decode_byte(input logic sol, input logic [7:0] b);
        t_result rec;
        if (sol) begin
            dec_phase        = PH_GRP_LEN;
            dec_bytes_left   = '0;
            dec_shift        = '0;
            dec_prefix_sum   = '0;
            dec_entry_sum    = '0;
            dec_entries_left = '0;
            dec_offset       = '0;
        end
        case (dec_phase)
            PH_PREFIX: begin
                dec_shift      = {dec_shift[55:0], b};
                dec_bytes_left = dec_bytes_left - 8'd1;
                if (dec_bytes_left == '0) begin
                    dec_prefix_sum   = dec_prefix_sum + dec_shift;
                    dec_shift        = '0;
                    dec_entries_left = '0;
                    dec_bytes_left   = COUNT_BYTES;
                    dec_phase        = PH_COUNT;
                end
            end
            PH_COUNT: begin
                dec_entries_left = {dec_entries_left[15:0], b};
                dec_bytes_left   = dec_bytes_left - 8'd1;
                if (dec_bytes_left == '0) begin
                    dec_entry_sum   = '0;
                    rec.record_kind = KIND_PREFIX;
                    rec.value       = dec_prefix_sum & PREFIX_MASK;
                    rec.out_offset  = dec_offset;
                    expected_records.push_back(rec);
                    dec_phase = (dec_entries_left == '0) ? PH_GRP_LEN : PH_ENT_LEN;
                end
            end
            PH_ENT_LEN: begin
                dec_shift = '0;
                if (b == '0) begin
                    close_entry();
                end else begin
                    dec_bytes_left = b;
                    dec_phase      = PH_ENT_DATA;
                end
            end
            PH_ENT_DATA: begin
                dec_shift      = {dec_shift[55:0], b};
                dec_bytes_left = dec_bytes_left - 8'd1;
                if (dec_bytes_left == '0) begin
                    dec_entry_sum = dec_entry_sum + dec_shift;
                    dec_shift     = '0;
                    close_entry();
                end
            end
            default: begin
                dec_shift = '0;
                if (b == '0) begin
                    dec_entries_left = '0;
                    dec_bytes_left   = COUNT_BYTES;
                    dec_phase        = PH_COUNT;
                end else begin
                    dec_bytes_left = b;
                    dec_phase      = PH_PREFIX;
                end
            end
        endcase
    endtask

    function automatic t_in_beat make_beat(input logic sol, input logic [7:0] b);
        t_in_beat bt;
        bt.start_of_list = sol;
        bt.data_byte     = b;
        return bt;
    endfunction

    task automatic put(input logic sol, input logic [7:0] b);
        stream_bytes.push_back(make_beat(sol, b));
    endtask

    // mostly short fields, some longer than the 64-bit register, rarely very long
    function automatic int rand_len();
        int r;
        r = $urandom_range(0, 119);
        if (r < 15) return 0;
        if (r < 27) return $urandom_range(9, 12);
        if (r < 29) return $urandom_range(13, 255);
        return $urandom_range(1, 8);
    endfunction

    task automatic add_group(input int count, input int body, input bit broken);
        t_in_beat grp[$];
        int       len;
        int       cut;
        logic [23:0] cnt;
        cnt = 24'(count);
        len = rand_len();
        grp.push_back(make_beat(restart_due || ($urandom_range(0, 9) == 0), 8'(len)));
        restart_due = 1'b0;
        repeat (len) grp.push_back(make_beat(1'b0, 8'($urandom_range(0, 255))));
        grp.push_back(make_beat(1'b0, cnt[23:16]));
        grp.push_back(make_beat(1'b0, cnt[15:8]));
        grp.push_back(make_beat(1'b0, cnt[7:0]));
        repeat (body) begin
            len = rand_len();
            grp.push_back(make_beat(1'b0, 8'(len)));
            repeat (len) grp.push_back(make_beat(1'b0, 8'($urandom_range(0, 255))));
        end
        if (broken && grp.size() > 1) begin
            cut = $urandom_range(1, grp.size() - 1);
            while (grp.size() > cut) void'(grp.pop_back());
        end
        restart_due = broken || (body < count);
        foreach (grp[k]) stream_bytes.push_back(grp[k]);
    endtask

    task automatic add_noise();
        repeat ($urandom_range(1, 8))
            put($urandom_range(0, 3) == 0, 8'($urandom_range(0, 255)));
        restart_due = 1'b1;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            cycles++;
            if (s_tvalid && s_tready) begin
                beats_taken++;
                if (s_tuser) restart_count++;
                decode_byte(s_tuser, s_tdata);
            end
            if (m_tvalid && m_tready) begin
                if (expected_records.size() == 0) begin
                    report_mismatch("unexpected", {63'd0, m_tuser}, 64'd0);
                end else begin
                    t_result exp;
                    exp = expected_records.pop_front();
                    if (m_tuser != exp.record_kind)
                        report_mismatch("record_kind", {63'd0, m_tuser},
                                        {63'd0, exp.record_kind});
                    if (m_tdata[63:0] != exp.value)
                        report_mismatch("value", m_tdata[63:0], exp.value);
                    if (m_tdata[95:64] != exp.out_offset)
                        report_mismatch("out_offset", {32'd0, m_tdata[95:64]},
                                        {32'd0, exp.out_offset});
                end
                if (m_tuser == KIND_PREFIX) prefix_count++;
                else entry_count++;
                records_taken++;
                if (records_taken % 60 == 0) recv_calm = ($urandom_range(0, 2) == 0);
                recv_gap = recv_calm ? 0 : $urandom_range(0, 6);
            end
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!(s_tvalid && beats_taken != beats_offered)) begin
                if (send_gap > 0) begin
                    s_tvalid <= 1'b0;
                    send_gap--;
                end else if (stream_bytes.size() > 0) begin
                    next_beat = stream_bytes.pop_front();
                    s_tdata  <= next_beat.data_byte;
                    s_tuser  <= next_beat.start_of_list;
                    s_tvalid <= 1'b1;
                    beats_offered++;
                    if (beats_offered % 80 == 0) send_calm = ($urandom_range(0, 2) == 0);
                    send_gap = send_calm ? 0 : $urandom_range(0, 6);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            if (recv_gap > 0) begin
                m_tready <= 1'b0;
                recv_gap--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        int r;
        int c;
        // empty group with zero-length prefix delta
        put(1'b1, 8'h00);
        put(1'b0, 8'h00); put(1'b0, 8'h00); put(1'b0, 8'h00);
        // prefix delta longer than 8 bytes, two entries
        put(1'b0, 8'h09);
        put(1'b0, 8'h12);
        repeat (8) put(1'b0, 8'hFF);
        put(1'b0, 8'h00); put(1'b0, 8'h00); put(1'b0, 8'h02);
        put(1'b0, 8'h00);
        put(1'b0, 8'h01); put(1'b0, 8'h80);
        // restart in the middle of a prefix delta
        put(1'b0, 8'h05); put(1'b0, 8'hAA);
        put(1'b1, 8'h00);
        put(1'b0, 8'h00); put(1'b0, 8'h00); put(1'b0, 8'h01);
        put(1'b0, 8'h00);

        while (stream_bytes.size() < TARGET_BYTES) begin
            r = $urandom_range(0, 99);
            if (r < 72) begin
                // complete group: every counted entry follows
                c = $urandom_range(0, 6);
                add_group(c, c, 1'b0);
            end
            else if (r < 82) add_group($urandom_range(1, 6), $urandom_range(0, 6), 1'b1);
            else if (r < 90) add_group($urandom_range(7, 24'hFFFFFF), $urandom_range(0, 4), 1'b0);
            else             add_noise();
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (stream_bytes.size() != 0 || beats_taken != beats_offered ||
               expected_records.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d bytes in, %0d list restarts; %0d prefix and %0d entry records checked",
                 beats_taken, restart_count, prefix_count, entry_count);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatches", errors);
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
